### sv/ipt_pkg.sv
`default_nettype none

package ipt_pkg;

    localparam int VALUE_W     = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int RANK_W      = 2;

    // register indexes on the write port
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_OFFSET = 2'd3;

    localparam logic [CFG_DATA_W-1:0] TRIGGER_LEVEL_RST  = 16'd5120;
    localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST  = 16'd300;
    localparam logic [CFG_DATA_W-1:0] HOLDOFF_LENGTH_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] GRAVITY_OFFSET_RST = 16'd1024;

    localparam logic [RANK_W-1:0] RANK_NONE = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] accel_x;
        logic signed [VALUE_W-1:0] accel_y;
        logic signed [VALUE_W-1:0] accel_z;
        logic [TIME_W-1:0]         time_ms;
    } in_item_t;

    typedef struct packed {
        logic                window_done;
        logic [VALUE_W-1:0]  window_peak;
        logic [RANK_W-1:0]   placed_rank;
        logic [VALUE_W-1:0]  best_first;
        logic [VALUE_W-1:0]  best_second;
        logic [VALUE_W-1:0]  best_third;
        logic                in_window;
        logic                sample_ignored;
    } out_item_t;

    // what one board cell shows its right-hand neighbor
    typedef struct packed {
        logic               gt;
        logic [VALUE_W-1:0] entry;
    } link_t;

endpackage

`default_nettype wire

### sv/ipt_if.sv
`default_nettype none

interface ipt_in_if;
    logic              valid;
    logic              ready;
    ipt_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipt_out_if;
    logic               valid;
    logic               ready;
    ipt_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/impact_peak_top3_tracker.sv
`default_nettype none

// Impact peak tracker. Each accepted sample (three signed axes in 1/1024 g and a
// millisecond timestamp) gives one result item. The vector length is the floor
// square root of the summed squares; its distance from gravity_offset is the
// deviation. A deviation above trigger_level opens a window whose peak is
// committed to a descending leaderboard once more than window_length ms have
// passed; samples in the following holdoff_length ms are flagged as ignored.
// A sample is taken only once the last one has passed squaring on a shared
// multiplier, the bit-serial square root (one result bit per cycle), decide,
// board insert and output load. The leaderboard is a chain of BOARD_DEPTH cells
// that all take an insert in the same cycle. A finished result waits in an
// output register, so the next sample is taken while it is unread. Register
// writes on the cfg port are taken at any time but belong in idle periods.
module impact_peak_top3_tracker #(
    parameter int BOARD_DEPTH = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ipt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ipt_pkg::CFG_DATA_W-1:0]   cfg_data,
    ipt_in_if.sink                           sample,
    ipt_out_if.source                        result
);

    localparam int RANK_CELLS = (BOARD_DEPTH < 3) ? BOARD_DEPTH : 3;
    localparam int VW = ipt_pkg::VALUE_W;
    localparam int TW = ipt_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DECIDE,
        S_PLACE,
        S_OUT
    } state_t;

    function automatic logic [VW-1:0] abs16(input logic signed [VW-1:0] v);
        abs16 = v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    // configuration
    logic [ipt_pkg::CFG_DATA_W-1:0] trigger_level_reg, window_length_reg;
    logic [ipt_pkg::CFG_DATA_W-1:0] holdoff_length_reg, gravity_offset_reg;

    // control and tracking state
    state_t          state_reg, state_next;
    logic [1:0]      sq_cnt_reg, sq_cnt_next;
    logic            window_open_reg, window_open_next;
    logic [TW-1:0]   window_start_reg, window_start_next;
    logic [VW-1:0]   running_peak_reg, running_peak_next;
    logic            holdoff_active_reg, holdoff_active_next;
    logic [TW-1:0]   holdoff_start_reg, holdoff_start_next;
    logic            out_valid_reg, out_valid_next;

    // per-item payload
    logic [VW-1:0]   axis_reg [3];
    logic [TW-1:0]   time_reg;
    logic [31:0]     acc_reg;
    logic            hold_flag_reg;
    logic            win_gt_reg;
    logic [VW-1:0]   dev_reg;
    logic [VW-1:0]   peak_reg, peak_next;
    logic            done_reg, done_next;
    logic            ignored_reg;
    logic [ipt_pkg::RANK_W-1:0] rank_reg;
    ipt_pkg::out_item_t out_reg, out_next;

    logic [31:0]     sq_w;
    logic [31:0]     sum_w;
    logic [TW-1:0]   hold_elapsed_w;
    logic [TW-1:0]   win_elapsed_w;
    logic            accept_w;
    logic            out_load_w;
    logic            root_start_w;
    logic            root_done_w;
    logic [VW-1:0]   root_w;
    logic            open_now_w;
    logic            close_w;
    logic            insert_w;
    logic [ipt_pkg::RANK_W-1:0] rank_w;
    logic [VW-1:0]   best1_w, best2_w;

    ipt_pkg::link_t  link_w [BOARD_DEPTH];

    assign accept_w     = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign out_load_w   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_level_reg  <= ipt_pkg::TRIGGER_LEVEL_RST;
            window_length_reg  <= ipt_pkg::WINDOW_LENGTH_RST;
            holdoff_length_reg <= ipt_pkg::HOLDOFF_LENGTH_RST;
            gravity_offset_reg <= ipt_pkg::GRAVITY_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipt_pkg::REG_TRIGGER_LEVEL:  trigger_level_reg  <= cfg_data;
                ipt_pkg::REG_WINDOW_LENGTH:  window_length_reg  <= cfg_data;
                ipt_pkg::REG_HOLDOFF_LENGTH: holdoff_length_reg <= cfg_data;
                ipt_pkg::REG_GRAVITY_OFFSET: gravity_offset_reg <= cfg_data;
            endcase
        end
    end

    // ---------------- magnitude ----------------
    assign sq_w  = axis_reg[0] * axis_reg[0];
    assign sum_w = acc_reg + sq_w;

    assign root_start_w = (state_reg == S_SQUARE) && (sq_cnt_reg == 2'd2);

    ipt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_w),
        .radicand (sum_w),
        .done     (root_done_w),
        .root     (root_w)
    );

    // elapsed times wrap modulo 2^32
    assign hold_elapsed_w = time_reg - holdoff_start_reg;
    assign win_elapsed_w  = time_reg - window_start_reg;

    // ---------------- leaderboard chain ----------------
    assign insert_w = (state_reg == S_PLACE) && done_reg;

    for (genvar k = 0; k < BOARD_DEPTH; k++)
    begin : g_cell
        ipt_pkg::link_t left_w;
        if (k == 0)
        begin : g_head
            assign left_w = '{gt: 1'b0, entry: '0};
        end
        else
        begin : g_body
            assign left_w = link_w[k-1];
        end
        ipt_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .insert (insert_w),
            .val    (peak_reg),
            .left   (left_w),
            .link   (link_w[k])
        );
    end

    // first cell that loses to the peak is where it lands; deeper ranks read as none
    always_comb
    begin
        rank_w = ipt_pkg::RANK_NONE;
        for (int k = RANK_CELLS - 1; k >= 0; k--)
        begin
            if (link_w[k].gt)
                rank_w = ipt_pkg::RANK_W'(k);
        end
    end

    if (BOARD_DEPTH > 1)
    begin : g_best1
        assign best1_w = link_w[1].entry;
    end
    else
    begin : g_no_best1
        assign best1_w = '0;
    end

    if (BOARD_DEPTH > 2)
    begin : g_best2
        assign best2_w = link_w[2].entry;
    end
    else
    begin : g_no_best2
        assign best2_w = '0;
    end

    // ---------------- window decision ----------------
    assign open_now_w = !hold_flag_reg && (dev_reg > trigger_level_reg) && !window_open_reg;
    assign close_w    = !hold_flag_reg && window_open_reg && win_gt_reg;

    always_comb
    begin
        state_next          = state_reg;
        sq_cnt_next         = sq_cnt_reg;
        window_open_next    = window_open_reg;
        window_start_next   = window_start_reg;
        running_peak_next   = running_peak_reg;
        holdoff_active_next = holdoff_active_reg;
        holdoff_start_next  = holdoff_start_reg;
        out_valid_next      = out_valid_reg && !result.ready;
        peak_next           = running_peak_reg;
        done_next           = 1'b0;

        out_next.window_done    = done_reg;
        out_next.window_peak    = peak_reg;
        out_next.placed_rank    = rank_reg;
        out_next.best_first     = link_w[0].entry;
        out_next.best_second    = best1_w;
        out_next.best_third     = best2_w;
        out_next.in_window      = window_open_reg;
        out_next.sample_ignored = ignored_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_w)
                begin
                    sq_cnt_next = '0;
                    state_next  = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd2)
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done_w)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (holdoff_active_reg && !hold_flag_reg)
                    holdoff_active_next = 1'b0;
                if (open_now_w)
                begin
                    window_open_next  = 1'b1;
                    window_start_next = time_reg;
                    running_peak_next = dev_reg;
                    peak_next         = dev_reg;
                end
                else if (!hold_flag_reg && window_open_reg)
                begin
                    if (dev_reg > running_peak_reg)
                    begin
                        running_peak_next = dev_reg;
                        peak_next         = dev_reg;
                    end
                end
                if (close_w)
                begin
                    done_next           = 1'b1;
                    window_open_next    = 1'b0;
                    running_peak_next   = '0;
                    holdoff_active_next = 1'b1;
                    holdoff_start_next  = time_reg;
                end
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load_w)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            sq_cnt_reg         <= '0;
            window_open_reg    <= 1'b0;
            window_start_reg   <= '0;
            running_peak_reg   <= '0;
            holdoff_active_reg <= 1'b0;
            holdoff_start_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sq_cnt_reg         <= sq_cnt_next;
            window_open_reg    <= window_open_next;
            window_start_reg   <= window_start_next;
            running_peak_reg   <= running_peak_next;
            holdoff_active_reg <= holdoff_active_next;
            holdoff_start_reg  <= holdoff_start_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept_w)
                begin
                    axis_reg[0] <= abs16(sample.data.accel_x);
                    axis_reg[1] <= abs16(sample.data.accel_y);
                    axis_reg[2] <= abs16(sample.data.accel_z);
                    time_reg    <= sample.data.time_ms;
                    acc_reg     <= '0;
                end
            end
            S_SQUARE:
            begin
                acc_reg       <= sum_w;
                axis_reg[0]   <= axis_reg[1];
                axis_reg[1]   <= axis_reg[2];
                hold_flag_reg <= holdoff_active_reg
                                 && (hold_elapsed_w < {16'b0, holdoff_length_reg});
                win_gt_reg    <= win_elapsed_w > {16'b0, window_length_reg};
            end
            S_ROOT:
            begin
                if (root_done_w)
                    dev_reg <= (root_w >= gravity_offset_reg) ? root_w - gravity_offset_reg
                                                              : gravity_offset_reg - root_w;
            end
            S_DECIDE:
            begin
                peak_reg    <= peak_next;
                done_reg    <= done_next;
                ignored_reg <= hold_flag_reg;
            end
            S_PLACE:
            begin
                rank_reg <= done_reg ? rank_w : ipt_pkg::RANK_NONE;
            end
            S_OUT:
            begin
                if (out_load_w)
                    out_reg <= out_next;
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a window can only open on a sample that ended any holdoff
    a_window_holdoff_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(window_open_reg && holdoff_active_reg))
        else $error("window open during holdoff");

    a_peak_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !window_open_reg |-> (running_peak_reg == '0))
        else $error("running peak nonzero with no window");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done_w |-> (state_reg == S_ROOT))
        else $error("square root finished outside its wait state");

    for (genvar k = 1; k < BOARD_DEPTH; k++)
    begin : g_order_chk
        a_board_order: assert property (@(posedge clk) disable iff (!rst_n)
            link_w[k].entry <= link_w[k-1].entry)
            else $error("leaderboard out of order");
    end
`endif

endmodule

`default_nettype wire

### sv/ipt_isqrt.sv
`default_nettype none

module ipt_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [31:0] rad_reg, rad_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;

    logic [18:0] rem_trial_w;
    logic [18:0] sub_trial_w;
    logic        ge_w;

    // one result bit per step: bring down two radicand bits, try 4*root+1
    assign rem_trial_w = {rem_reg, rad_reg[31:30]};
    assign sub_trial_w = {1'b0, root_reg, 2'b01};
    assign ge_w        = rem_trial_w >= sub_trial_w;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[29:0], 2'b00};
            rem_next  = ge_w ? 17'(rem_trial_w - sub_trial_w) : 17'(rem_trial_w);
            root_next = {root_reg[14:0], ge_w};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### sv/ipt_cell.sv
`default_nettype none

module ipt_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         insert,
    input  logic [ipt_pkg::VALUE_W-1:0]  val,
    input  ipt_pkg::link_t               left,
    output ipt_pkg::link_t               link
);

    logic [ipt_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic                        gt_w;

    assign gt_w = val > entry_reg;

    // board is descending: if the left cell also loses to val, shift its entry in
    always_comb
    begin
        entry_next = entry_reg;
        if (insert)
        begin
            if (left.gt)
                entry_next = left.entry;
            else if (gt_w)
                entry_next = val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign link.gt    = gt_w;
    assign link.entry = entry_reg;

endmodule

`default_nettype wire
